// ===== hdl/salc_pkg.sv =====
// shared types and constants of the set-associative lru cache tracker
`timescale 1ns / 1ps

package salc_pkg;

  // cache geometry
  localparam int MAX_SET_BITS = 6;
  localparam int WAYS         = 4;
  localparam int TIME_BITS    = 48;

  localparam int ADDR_W    = 64;
  localparam int TAG_W     = 64;
  localparam int CNT_W     = 32;
  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int IDX_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SB_W      = $clog2(MAX_SET_BITS + 2);
  localparam int NW_W      = $clog2(WAYS + 2);
  localparam int TSH_W     = $clog2(ADDR_W + MAX_SET_BITS + 1);

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [2:0] RST_SET_BITS    = 3'd4;
  localparam logic [5:0] RST_BLOCK_BITS  = 6'd4;
  localparam logic [2:0] RST_WAYS_IN_USE = 3'd4;

  // access kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  // outcome of the first access
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic [1:0]        access_kind;
    logic [ADDR_W-1:0] access_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       first_outcome;
    logic             second_hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] evict_count;
  } out_item_t;

  // one cache line as kept in the set memory
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [TIME_BITS-1:0] lru;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

endpackage

// ===== hdl/set_assoc_lru_cache_tracker.sv =====
// set-associative lru cache tracker: hit, miss and eviction accounting per access
`timescale 1ns / 1ps

// usage
//   input channel (in_valid / in_stall / in_data) carries one access transaction:
//   a kind (load, store, modify) and a 64-bit byte address. every input
//   transaction yields exactly one output transaction (out_valid / out_stall /
//   out_data) with the first access outcome, the modify second-hit flag and the
//   saturating hit, miss and eviction totals after the access.
//   cfg_wr_en / cfg_index / cfg_wdata write set_bits, block_bits and ways_in_use;
//   write them only while no transaction is in flight.
// timing
//   an accepted access reads its set row from the line memory on the accept
//   edge; once the output register is free, the back end does the tag match,
//   victim choice and write-back and loads the output register. one access
//   is in flight at a time: a new access is taken only after the last one
//   has completed. a modify is done in the same pass as a single access.
// reset
//   rst_n low clears all valid bits (flip-flops), the counters, the access
//   clock (to one) and the config registers to 4/4/4; tags and lru times are
//   only looked at for valid lines, so the memory needs no clearing pass.
// stall: a held result blocks the write-back of the next access until
//   out_stall drops; in_stall stays high for that whole time.

module set_assoc_lru_cache_tracker
  import salc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // config registers
  logic [2:0] cfg_set_bits_r;
  logic [5:0] cfg_block_bits_r;
  logic [2:0] cfg_ways_r;

  // line memory and valid bits
  row_t           line_mem [NUM_SETS];
  logic [WAYS-1:0] valid_r [NUM_SETS];
  row_t           rd_row_r;

  // access in flight
  logic                 busy_r;
  logic [IDX_W-1:0]     set_r;
  logic [TAG_W-1:0]     tag_r;
  logic [1:0]           kind_r;

  // global state
  logic [TIME_BITS-1:0] clock_r;
  logic [TIME_BITS-1:0] clock_nxt;
  logic [CNT_W-1:0]     hits_r;
  logic [CNT_W-1:0]     misses_r;
  logic [CNT_W-1:0]     evicts_r;
  logic [CNT_W-1:0]     hits_nxt;
  logic [CNT_W-1:0]     misses_nxt;
  logic [CNT_W-1:0]     evicts_nxt;

  logic      out_valid_r;
  out_item_t out_data_r;

  // front end signals
  logic                 in_accept;
  logic [SB_W-1:0]      sb_eff;
  logic [NW_W-1:0]      nw_eff;
  logic [ADDR_W-1:0]    addr_shift;
  logic [IDX_W-1:0]     set_mask;
  logic [IDX_W-1:0]     rd_set;
  logic [TSH_W-1:0]     tag_shift;
  logic [TAG_W-1:0]     rd_tag;

  // back end signals
  logic                 fire;
  logic                 is_access;
  logic                 is_modify;
  logic [WAYS-1:0]      row_valid;
  logic                 hit_found;
  logic [WAY_W-1:0]     hit_way;
  logic                 empty_found;
  logic [WAY_W-1:0]     empty_way;
  logic                 have_valid;
  logic [TIME_BITS-1:0] best_age;
  logic [TIME_BITS-1:0] age;
  logic [WAY_W-1:0]     lru_way;
  logic [WAY_W-1:0]     sel_way;
  logic                 evict;
  logic [TIME_BITS-1:0] stamp;
  row_t                 wr_row;
  logic [1:0]           first_outcome;
  logic [1:0]           hit_inc;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W + 1)'(n);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // one access at a time; the set row is read on the accept edge
  assign in_stall  = busy_r | ~rst_n;
  assign in_accept = in_valid & ~in_stall;

  // clamp of the configured geometry
  always_comb begin
    if (int'(cfg_set_bits_r) > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SB_W'(cfg_set_bits_r);
    end
    if (cfg_ways_r == 3'd0) begin
      nw_eff = NW_W'(1);
    end else if (int'(cfg_ways_r) > WAYS) begin
      nw_eff = NW_W'(WAYS);
    end else begin
      nw_eff = NW_W'(cfg_ways_r);
    end
  end

  // address split: offset, set index, tag
  always_comb begin
    addr_shift = in_data.access_address >> cfg_block_bits_r;
    for (int i = 0; i < IDX_W; i++) begin
      set_mask[i] = (i < int'(sb_eff));
    end
    rd_set    = addr_shift[IDX_W-1:0] & set_mask;
    tag_shift = TSH_W'(cfg_block_bits_r) + TSH_W'(sb_eff);
    if (int'(tag_shift) >= ADDR_W) begin
      rd_tag = '0;
    end else begin
      rd_tag = in_data.access_address >> tag_shift;
    end
  end

  // back end: match, victim choice, write-back row
  assign fire      = busy_r & (~out_valid_r | ~out_stall);
  assign is_access = kind_r inside {KIND_LOAD, KIND_STORE, KIND_MODIFY};
  assign is_modify = (kind_r == KIND_MODIFY);
  assign row_valid = valid_r[set_r];

  always_comb begin
    hit_found   = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    have_valid  = 1'b0;
    best_age    = '0;
    lru_way     = '0;
    age         = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (w < int'(nw_eff)) begin
        if (!hit_found && row_valid[w] && rd_row_r[w].tag == tag_r) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!row_valid[w]) begin
          if (!empty_found) begin
            empty_found = 1'b1;
            empty_way   = WAY_W'(w);
          end
        end else begin
          // oldest valid way, lowest index on ties
          age = clock_r - rd_row_r[w].lru;
          if (!have_valid || age > best_age) begin
            have_valid = 1'b1;
            best_age   = age;
            lru_way    = WAY_W'(w);
          end
        end
      end
    end
  end

  always_comb begin
    evict = ~hit_found & ~empty_found;
    if (hit_found) begin
      sel_way = hit_way;
    end else if (empty_found) begin
      sel_way = empty_way;
    end else begin
      sel_way = lru_way;
    end
    // a modify's second access always hits the same line, so it is stamped with the access clock plus one
    stamp  = is_modify ? clock_r + TIME_BITS'(1) : clock_r;
    wr_row = rd_row_r;
    wr_row[sel_way].tag = tag_r;
    wr_row[sel_way].lru = stamp;

    if (hit_found) begin
      first_outcome = OUT_HIT;
    end else if (empty_found) begin
      first_outcome = OUT_MISS;
    end else begin
      first_outcome = OUT_EVICT;
    end

    hit_inc = {1'b0, hit_found} + {1'b0, is_modify};
    if (is_access) begin
      clock_nxt  = clock_r + (is_modify ? TIME_BITS'(2) : TIME_BITS'(1));
      hits_nxt   = sat_add(hits_r, hit_inc);
      misses_nxt = sat_add(misses_r, {1'b0, ~hit_found});
      evicts_nxt = sat_add(evicts_r, {1'b0, evict});
    end else begin
      clock_nxt  = clock_r;
      hits_nxt   = hits_r;
      misses_nxt = misses_r;
      evicts_nxt = evicts_r;
    end
  end

  // set memory: read at accept, write-back at completion
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_row_r <= line_mem[rd_set];
    end
    if (fire && is_access) begin
      line_mem[set_r] <= wr_row;
    end
  end

  // access payload held for the back end
  always_ff @(posedge clk) begin
    if (in_accept) begin
      set_r  <= rd_set;
      tag_r  <= rd_tag;
      kind_r <= in_data.access_kind;
    end
  end

  // control, valid bits, counters, config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r           <= 1'b0;
      out_valid_r      <= 1'b0;
      clock_r          <= TIME_BITS'(1);
      hits_r           <= '0;
      misses_r         <= '0;
      evicts_r         <= '0;
      cfg_set_bits_r   <= RST_SET_BITS;
      cfg_block_bits_r <= RST_BLOCK_BITS;
      cfg_ways_r       <= RST_WAYS_IN_USE;
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end

      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (fire) begin
        clock_r  <= clock_nxt;
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        evicts_r <= evicts_nxt;
        if (is_access) begin
          valid_r[set_r][sel_way] <= 1'b1;
        end
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SET_BITS:    cfg_set_bits_r   <= cfg_wdata[2:0];
          CFG_BLOCK_BITS:  cfg_block_bits_r <= cfg_wdata[5:0];
          CFG_WAYS_IN_USE: cfg_ways_r       <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.first_outcome <= is_access ? first_outcome : OUT_HIT;
      out_data_r.second_hit    <= is_modify;
      out_data_r.hit_count     <= hits_nxt;
      out_data_r.miss_count    <= misses_nxt;
      out_data_r.evict_count   <= evicts_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> busy_r)
    else $error("accepted access did not mark the block busy");

  a_fire_result : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_valid_r && !busy_r))
    else $error("completed access did not present a result");

  a_clock_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(clock_r))
    else $error("access clock moved without a completed access");

  a_hits_mono : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (hits_r >= $past(hits_r)) && (misses_r >= $past(misses_r)))
    else $error("saturating counter decreased");
`endif

endmodule
